// File: src/dcctwg_pkg.sv
// Package for the DCC track waveform generator: payload structs, codes,
// frame states and reset constants. No dependencies.
package dcctwg_pkg;

   // Request payload (one tick or one packet offer)
   typedef struct packed {
      logic        func;
      logic        rail_power;
      logic [47:0] packet_bytes;
      logic [2:0]  packet_len;
      logic        packet_service;
   } req_payload_type;

   // Response payload (one per request)
   typedef struct packed {
      logic [1:0] half_period;
      logic [1:0] rail_a;
      logic [1:0] rail_b;
      logic       aux_level;
      logic       cutout_active;
      logic       need_packet;
      logic       idle_substituted;
   } rsp_payload_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_RAILCOM_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_S88_ENABLE      = 3'd1;
   localparam logic [2:0] CSR_PREAMBLE_BITS   = 3'd2;
   localparam logic [2:0] CSR_CUTOUT_BITS     = 3'd3;
   localparam logic [2:0] CSR_LONG_PRE_EXTRA  = 3'd4;

   localparam logic [5:0] PREAMBLE_RESET   = 6'd16;
   localparam logic [5:0] CUTOUT_RESET     = 6'd4;
   localparam logic [5:0] LONG_PRE_RESET   = 6'd8;
   localparam logic [5:0] BITS_PER_BYTE    = 6'd8;

   typedef struct packed {
      logic       railcom_enable;
      logic       s88_enable;
      logic [5:0] preamble_bits;
      logic [5:0] cutout_bits;
      logic [5:0] long_preamble_extra;
   } cfg_type;

   // Half-period codes
   localparam logic [1:0] HP_ONE   = 2'd0;
   localparam logic [1:0] HP_ZHIGH = 2'd1;
   localparam logic [1:0] HP_ZLOW  = 2'd2;
   localparam logic [1:0] HP_HALF  = 2'd3;

   // Rail drive codes
   localparam logic [1:0] RAIL_HOLD = 2'd0;
   localparam logic [1:0] RAIL_LOW  = 2'd1;
   localparam logic [1:0] RAIL_HIGH = 2'd2;
   localparam logic [1:0] RAIL_CUT  = 2'd3;

   // Idle packet bytes
   localparam logic [7:0] IDLE_BYTE0 = 8'hFF;
   localparam logic [7:0] IDLE_BYTE1 = 8'h00;
   localparam logic [7:0] IDLE_BYTE2 = 8'hFF;
   localparam int         IDLE_LEN   = 3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PRE, ST_LONGPRE, ST_BSTART, ST_NEXTBYTE, ST_BYTE, ST_END
   } frame_state_type;

   typedef enum logic {
      KIND_TICK, KIND_OFFER
   } item_kind_type;

   // Classified item as it travels through the queue
   typedef struct packed {
      item_kind_type kind;
      logic          power;
      logic          service;
      logic [47:0]   bytes;
   } item_type;

   localparam int QUEUE_DEPTH = 2;

endpackage

// File: src/dcctwg_front.sv
// Front end: classifies requests (tick or offer, length clamp) and
// buffers them in a two-entry queue. Depends on dcctwg_pkg.
module dcctwg_front #(
   parameter int MAX_PACKET_BYTES = 6,
   parameter int LEN_W = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  dcctwg_pkg::req_payload_type req_payload,
   output logic                       q_valid,
   output dcctwg_pkg::item_type       q_item,
   output logic [LEN_W-1:0]           q_len,
   input  logic                       q_pop
);

   localparam int DEPTH = dcctwg_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   dcctwg_pkg::item_type item_ff [DEPTH];
   logic [LEN_W-1:0]     len_ff  [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   dcctwg_pkg::item_type item_in;
   logic [LEN_W-1:0]     len_in;
   logic                 push;
   logic                 pop;

   // classify
   always_comb begin
      item_in.kind    = req_payload.func ? dcctwg_pkg::KIND_OFFER : dcctwg_pkg::KIND_TICK;
      item_in.power   = req_payload.rail_power;
      item_in.service = req_payload.packet_service;
      item_in.bytes   = req_payload.packet_bytes;
      if (int'(req_payload.packet_len) > MAX_PACKET_BYTES) begin
         len_in = LEN_W'(MAX_PACKET_BYTES);
      end else if (req_payload.packet_len == 3'd0) begin
         len_in = LEN_W'(1);
      end else begin
         len_in = LEN_W'(req_payload.packet_len);
      end
   end

   assign req_ready = (count_ff != (PTR_W+1)'(DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = item_ff[rd_ptr_ff];
   assign q_len     = len_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= item_in;
         len_ff[wr_ptr_ff]  <= len_in;
      end
   end

endmodule

// File: src/dcctwg_back.sv
// Back end: frame sequencer, packet double buffer and rail drive, with
// the response output register. Depends on dcctwg_pkg.
module dcctwg_back #(
   parameter int MAX_PACKET_BYTES = 6,
   parameter int LEN_W = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dcctwg_pkg::cfg_type         cfg,
   input  logic                        q_valid,
   input  dcctwg_pkg::item_type        q_item,
   input  logic [LEN_W-1:0]            q_len,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output dcctwg_pkg::rsp_payload_type rsp_payload
);

   localparam int IDX_W = $clog2(MAX_PACKET_BYTES);

   typedef logic [MAX_PACKET_BYTES-1:0][7:0] buf_type;

   logic                        phase_high_ff, phase_high_in;
   dcctwg_pkg::frame_state_type frame_state_ff, frame_state_in;
   logic [5:0]                  bit_count_ff, bit_count_in;
   logic [LEN_W-1:0]            bytes_left_ff, bytes_left_in;
   buf_type                     send_buffer_ff, send_buffer_in;
   logic [LEN_W-1:0]            send_length_ff, send_length_in;
   buf_type                     next_buffer_ff, next_buffer_in;
   logic [LEN_W-1:0]            next_length_ff, next_length_in;
   logic                        next_service_ff, next_service_in;
   logic                        buffer_free_ff, buffer_free_in;
   logic                        cutout_on_ff, cutout_on_in;
   logic                        half_pending_ff, half_pending_in;
   logic [1:0]                  last_period_ff, last_period_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   dcctwg_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic             fire;
   logic             is_offer;
   logic             is_half;
   logic [1:0]       hp;
   logic [1:0]       ra;
   logic [1:0]       rb;
   logic             idle_sub;
   logic [5:0]       target;
   logic [LEN_W-1:0] byte_idx;
   logic [7:0]       cur_byte;
   logic [2:0]       bit_sh;
   logic             cur_bit;
   logic [63:0]      padded;
   buf_type          offer_buf;
   buf_type          idle_buf;

   assign fire     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop    = fire;
   assign is_offer = (q_item.kind == dcctwg_pkg::KIND_OFFER);
   assign is_half  = !is_offer && half_pending_ff;
   assign phase_high_in = (is_offer || is_half) ? phase_high_ff : !phase_high_ff;

   assign target = (cfg.cutout_bits >= cfg.preamble_bits) ? 6'd0
                 : cfg.preamble_bits - cfg.cutout_bits;

   // current data bit
   always_comb begin
      byte_idx = (bytes_left_ff <= send_length_ff) ? send_length_ff - bytes_left_ff : '0;
      if (int'(byte_idx) < MAX_PACKET_BYTES) begin
         cur_byte = send_buffer_ff[byte_idx[IDX_W-1:0]];
      end else begin
         cur_byte = '0;
      end
      if (bit_count_ff >= 6'd1 && bit_count_ff <= dcctwg_pkg::BITS_PER_BYTE) begin
         bit_sh = 3'(bit_count_ff - 6'd1);
      end else begin
         bit_sh = '0;
      end
      cur_bit = cur_byte[bit_sh];
   end

   // packet unpack and idle packet
   always_comb begin
      padded = {q_item.bytes, 16'h0000};
      for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
         offer_buf[i] = (i < 6) ? padded[63-8*i -: 8] : 8'h00;
         idle_buf[i]  = 8'h00;
      end
      idle_buf[0] = dcctwg_pkg::IDLE_BYTE0;
      idle_buf[1] = dcctwg_pkg::IDLE_BYTE1;
      idle_buf[2] = dcctwg_pkg::IDLE_BYTE2;
   end

   // next state
   always_comb begin
      frame_state_in  = frame_state_ff;
      bit_count_in    = bit_count_ff;
      bytes_left_in   = bytes_left_ff;
      send_buffer_in  = send_buffer_ff;
      send_length_in  = send_length_ff;
      next_buffer_in  = next_buffer_ff;
      next_length_in  = next_length_ff;
      next_service_in = next_service_ff;
      buffer_free_in  = buffer_free_ff;
      cutout_on_in    = cutout_on_ff;
      half_pending_in = half_pending_ff;
      last_period_in  = hp;
      if (is_offer) begin
         next_buffer_in  = offer_buf;
         next_length_in  = q_len;
         next_service_in = q_item.service;
         buffer_free_in  = 1'b0;
      end else if (is_half) begin
         half_pending_in = 1'b0;
      end else if (!phase_high_in) begin
         if (frame_state_ff == dcctwg_pkg::ST_PRE && bit_count_ff <= target) begin
            cutout_on_in = 1'b0;
         end
      end else begin
         case (frame_state_ff)
            dcctwg_pkg::ST_IDLE, dcctwg_pkg::ST_PRE: begin
               if (frame_state_ff == dcctwg_pkg::ST_IDLE) begin
                  frame_state_in = dcctwg_pkg::ST_PRE;
                  if (cfg.railcom_enable && !next_service_ff) begin
                     cutout_on_in    = 1'b1;
                     half_pending_in = 1'b1;
                  end
               end
               if (bit_count_ff <= 6'd1) begin
                  cutout_on_in = 1'b0;
                  if (next_service_ff) begin
                     bit_count_in   = cfg.long_preamble_extra;
                     frame_state_in = dcctwg_pkg::ST_LONGPRE;
                  end else begin
                     bit_count_in   = '0;
                     frame_state_in = dcctwg_pkg::ST_BSTART;
                  end
               end else begin
                  bit_count_in = bit_count_ff - 6'd1;
               end
            end
            dcctwg_pkg::ST_LONGPRE: begin
               if (bit_count_ff <= 6'd1) begin
                  bit_count_in   = '0;
                  frame_state_in = dcctwg_pkg::ST_BSTART;
               end else begin
                  bit_count_in = bit_count_ff - 6'd1;
               end
            end
            dcctwg_pkg::ST_BSTART: begin
               if (buffer_free_ff) begin
                  send_buffer_in = idle_buf;
                  send_length_in = LEN_W'(dcctwg_pkg::IDLE_LEN);
               end else begin
                  send_buffer_in = next_buffer_ff;
                  send_length_in = next_length_ff;
               end
               buffer_free_in = 1'b1;
               frame_state_in = dcctwg_pkg::ST_BYTE;
               bit_count_in   = dcctwg_pkg::BITS_PER_BYTE;
               bytes_left_in  = send_length_in;
            end
            dcctwg_pkg::ST_NEXTBYTE: begin
               frame_state_in = dcctwg_pkg::ST_BYTE;
               bit_count_in   = dcctwg_pkg::BITS_PER_BYTE;
            end
            dcctwg_pkg::ST_BYTE: begin
               if (bit_count_ff <= 6'd1) begin
                  bit_count_in = '0;
                  if (bytes_left_ff <= LEN_W'(1)) begin
                     bytes_left_in  = '0;
                     frame_state_in = dcctwg_pkg::ST_END;
                  end else begin
                     bytes_left_in  = bytes_left_ff - LEN_W'(1);
                     frame_state_in = dcctwg_pkg::ST_NEXTBYTE;
                  end
               end else begin
                  bit_count_in = bit_count_ff - 6'd1;
               end
            end
            default: begin
               frame_state_in = dcctwg_pkg::ST_IDLE;
               bit_count_in   = cfg.preamble_bits;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      hp       = last_period_ff;
      ra       = dcctwg_pkg::RAIL_HOLD;
      rb       = dcctwg_pkg::RAIL_HOLD;
      idle_sub = 1'b0;
      if (is_offer) begin
         hp = last_period_ff;
      end else if (is_half) begin
         hp = dcctwg_pkg::HP_HALF;
         ra = q_item.power ? dcctwg_pkg::RAIL_CUT : dcctwg_pkg::RAIL_HOLD;
      end else begin
         if (!q_item.power) begin
            ra = dcctwg_pkg::RAIL_HOLD;
         end else if (cutout_on_ff) begin
            ra = dcctwg_pkg::RAIL_CUT;
         end else begin
            ra = phase_high_in ? dcctwg_pkg::RAIL_HIGH : dcctwg_pkg::RAIL_LOW;
         end
         rb = ra;
         if (!phase_high_in) begin
            hp = (last_period_ff == dcctwg_pkg::HP_ZHIGH) ? dcctwg_pkg::HP_ZLOW
               : dcctwg_pkg::HP_ONE;
         end else begin
            case (frame_state_ff)
               dcctwg_pkg::ST_IDLE: begin
                  hp = (cfg.railcom_enable && !next_service_ff) ? dcctwg_pkg::HP_HALF
                     : dcctwg_pkg::HP_ONE;
               end
               dcctwg_pkg::ST_PRE, dcctwg_pkg::ST_LONGPRE: hp = dcctwg_pkg::HP_ONE;
               dcctwg_pkg::ST_BSTART: begin
                  hp       = dcctwg_pkg::HP_ZHIGH;
                  idle_sub = buffer_free_ff;
               end
               dcctwg_pkg::ST_NEXTBYTE: hp = dcctwg_pkg::HP_ZHIGH;
               dcctwg_pkg::ST_BYTE: begin
                  hp = cur_bit ? dcctwg_pkg::HP_ONE : dcctwg_pkg::HP_ZHIGH;
               end
               default: hp = dcctwg_pkg::HP_ONE;
            endcase
         end
      end
      rsp_payload_in.half_period      = hp;
      rsp_payload_in.rail_a           = ra;
      rsp_payload_in.rail_b           = rb;
      rsp_payload_in.aux_level        = cfg.s88_enable && phase_high_in;
      rsp_payload_in.cutout_active    = cutout_on_in;
      rsp_payload_in.need_packet      = buffer_free_in;
      rsp_payload_in.idle_substituted = idle_sub;
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_high_ff   <= 1'b0;
         frame_state_ff  <= dcctwg_pkg::ST_IDLE;
         bit_count_ff    <= dcctwg_pkg::PREAMBLE_RESET;
         bytes_left_ff   <= '0;
         send_buffer_ff  <= '0;
         send_length_ff  <= '0;
         next_buffer_ff  <= '0;
         next_length_ff  <= '0;
         next_service_ff <= 1'b0;
         buffer_free_ff  <= 1'b1;
         cutout_on_ff    <= 1'b0;
         half_pending_ff <= 1'b0;
         last_period_ff  <= dcctwg_pkg::HP_ONE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_high_ff   <= phase_high_in;
            frame_state_ff  <= frame_state_in;
            bit_count_ff    <= bit_count_in;
            bytes_left_ff   <= bytes_left_in;
            send_buffer_ff  <= send_buffer_in;
            send_length_ff  <= send_length_in;
            next_buffer_ff  <= next_buffer_in;
            next_length_ff  <= next_length_in;
            next_service_ff <= next_service_in;
            buffer_free_ff  <= buffer_free_in;
            cutout_on_ff    <= cutout_on_in;
            half_pending_ff <= half_pending_in;
            last_period_ff  <= last_period_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: src/dcc_track_waveform_generator_top.sv
// Path: an accepted request is written into the queue, and from the queue head the
// sequencer then loads the response register.
// Throughput: one request per cycle absent response stalls; the sequencer updates its
// state once per request; the two-entry queue and response register absorb stalls.
// Reset (synchronous): config registers to defaults, frame idle, phase low,
// queue and response register empty; no clearing pass.
// Top level: config registers, front end (classify + queue), back end
// (sequencer + response register). Depends on dcctwg_pkg, dcctwg_front, dcctwg_back.
module dcc_track_waveform_generator_top #(
   parameter int MAX_PACKET_BYTES = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel: ticks and packet offers
   input  logic                        req_valid,
   output logic                        req_ready,
   input  dcctwg_pkg::req_payload_type req_payload,
   // response channel: one per request
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output dcctwg_pkg::rsp_payload_type rsp_payload,
   // config write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [5:0]                  csr_wdata
);

   // length and byte counters hold 0..MAX_PACKET_BYTES
   localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1);

   dcctwg_pkg::cfg_type  cfg_ff, cfg_in;
   logic                 q_valid;
   dcctwg_pkg::item_type q_item;
   logic [LEN_W-1:0]     q_len;
   logic                 q_pop;

   // config writes always accepted; unknown indexes are ignored
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dcctwg_pkg::CSR_RAILCOM_ENABLE: cfg_in.railcom_enable      = csr_wdata[0];
            dcctwg_pkg::CSR_S88_ENABLE:     cfg_in.s88_enable          = csr_wdata[0];
            dcctwg_pkg::CSR_PREAMBLE_BITS:  cfg_in.preamble_bits       = csr_wdata;
            dcctwg_pkg::CSR_CUTOUT_BITS:    cfg_in.cutout_bits         = csr_wdata;
            dcctwg_pkg::CSR_LONG_PRE_EXTRA: cfg_in.long_preamble_extra = csr_wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.railcom_enable      <= 1'b0;
         cfg_ff.s88_enable          <= 1'b0;
         cfg_ff.preamble_bits       <= dcctwg_pkg::PREAMBLE_RESET;
         cfg_ff.cutout_bits         <= dcctwg_pkg::CUTOUT_RESET;
         cfg_ff.long_preamble_extra <= dcctwg_pkg::LONG_PRE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: decode tick/offer, clamp packet length, queue
   dcctwg_front #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
      .LEN_W(LEN_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_len(q_len),
      .q_pop(q_pop)
   );

   // back: frame sequencer, double buffer, rail drive, response register
   dcctwg_back #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
      .LEN_W(LEN_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_len(q_len),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the DCC track waveform generator: directed rows,
// then phased random ticks and packet offers. A built-in predictor computes each response.
// Depends on dcctwg_pkg and dcc_track_waveform_generator_top.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PKT_MAX     = 6;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 80;
   localparam int CYCLE_LIMIT = 100000;
   localparam int TAIL_CYCLES = 8;

   typedef enum logic { ROW_REQ, ROW_CSR } row_kind_type;

   // One directed row. It holds either a request or a register write. A typed row
   // carries its expected response. Other rows are checked against the predictor.
   typedef struct packed {
      row_kind_type                kind;
      dcctwg_pkg::req_payload_type req;
      logic [2:0]                  csr_idx;
      logic [5:0]                  csr_val;
      logic                        typed;
      dcctwg_pkg::rsp_payload_type want;
   } step_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   dcctwg_pkg::req_payload_type req_payload;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   dcctwg_pkg::rsp_payload_type rsp_payload;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [2:0]                  csr_index;
   logic [5:0]                  csr_wdata;

   dcc_track_waveform_generator_top #(
      .MAX_PACKET_BYTES(PKT_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Predictor state. It mirrors the block's sequencer, buffers and registers.
   // ---------------------------------------------------------------------------
   dcctwg_pkg::cfg_type         cfg_shadow;
   logic                        phase_level;
   dcctwg_pkg::frame_state_type frame_st;
   logic [5:0]                  bit_cnt;
   logic [2:0]                  bytes_rem;
   logic [7:0]                  send_buf [PKT_MAX];
   logic [7:0]                  next_buf [PKT_MAX];
   logic [2:0]                  send_len;
   logic [2:0]                  next_len;
   logic                        next_svc;
   logic                        buf_free;
   logic                        cut_on;
   logic                        half_pending;
   logic [1:0]                  last_hp;

   dcctwg_pkg::rsp_payload_type expected_waveform_q[$];
   step_row_type                directed_steps[$];

   // The driver sets these while a request is on the bus, and the monitor reads them
   // when the request is accepted.
   logic                        pin_typed;
   dcctwg_pkg::rsp_payload_type pin_want;

   int error_count = 0;
   int cycle_count = 0;
   int idle_pct;
   int stall_pct;
   int offer_pct;

   function automatic void reset_predictor();
      int i;
      cfg_shadow   = {1'b0, 1'b0, dcctwg_pkg::PREAMBLE_RESET, dcctwg_pkg::CUTOUT_RESET,
                      dcctwg_pkg::LONG_PRE_RESET};
      phase_level  = 1'b0;
      frame_st     = dcctwg_pkg::ST_IDLE;
      bit_cnt      = dcctwg_pkg::PREAMBLE_RESET;
      bytes_rem    = 3'd0;
      for (i = 0; i < PKT_MAX; i++) begin
         send_buf[i] = 8'h00;
         next_buf[i] = 8'h00;
      end
      send_len     = 3'd0;
      next_len     = 3'd0;
      next_svc     = 1'b0;
      buf_free     = 1'b1;
      cut_on       = 1'b0;
      half_pending = 1'b0;
      last_hp      = dcctwg_pkg::HP_ONE;
   endfunction

   // Advances the predictor by one accepted request and returns the response.
   function automatic dcctwg_pkg::rsp_payload_type predict_waveform(
         input dcctwg_pkg::req_payload_type r);
      dcctwg_pkg::rsp_payload_type o;
      logic [1:0]      hp;
      logic [1:0]      ra;
      logic [1:0]      rb;
      logic [5:0]      target;
      logic [5:0]      shift_full;
      logic [2:0]      len;
      logic [2:0]      idx;
      logic [2:0]      sh;
      logic [7:0]      cur;
      logic            idle_sub;
      int              i;
      idle_sub = 1'b0;

      if (r.func == dcctwg_pkg::KIND_OFFER) begin
         // Store the offer in the next buffer. An unsent packet is overwritten.
         for (i = 0; i < PKT_MAX; i++)
            next_buf[i] = r.packet_bytes[47 - 8 * i -: 8];
         len = r.packet_len;
         if (len == 3'd0) len = 3'd1;
         if (len > PKT_MAX) len = 3'(PKT_MAX);
         next_len = len;
         next_svc = r.packet_service;
         buf_free = 1'b0;
         o = {last_hp, dcctwg_pkg::RAIL_HOLD, dcctwg_pkg::RAIL_HOLD,
              cfg_shadow.s88_enable & phase_level, cut_on, buf_free, 1'b0};
         return o;
      end

      if (half_pending) begin
         // The second half-length one. The phase holds and only rail A is driven.
         half_pending = 1'b0;
         last_hp      = dcctwg_pkg::HP_HALF;
         o = {dcctwg_pkg::HP_HALF,
              r.rail_power ? dcctwg_pkg::RAIL_CUT : dcctwg_pkg::RAIL_HOLD,
              dcctwg_pkg::RAIL_HOLD,
              cfg_shadow.s88_enable & phase_level, cut_on, buf_free, 1'b0};
         return o;
      end

      phase_level = ~phase_level;
      if (!r.rail_power) begin
         ra = dcctwg_pkg::RAIL_HOLD;
         rb = dcctwg_pkg::RAIL_HOLD;
      end else if (cut_on) begin
         ra = dcctwg_pkg::RAIL_CUT;
         rb = dcctwg_pkg::RAIL_CUT;
      end else begin
         ra = phase_level ? dcctwg_pkg::RAIL_HIGH : dcctwg_pkg::RAIL_LOW;
         rb = ra;
      end

      if (!phase_level) begin
         // Low half: a zero bit finishes, and the cutout may end here.
         target = (cfg_shadow.cutout_bits >= cfg_shadow.preamble_bits) ? 6'd0 :
                  cfg_shadow.preamble_bits - cfg_shadow.cutout_bits;
         hp = (last_hp == dcctwg_pkg::HP_ZHIGH) ? dcctwg_pkg::HP_ZLOW : dcctwg_pkg::HP_ONE;
         if (frame_st == dcctwg_pkg::ST_PRE && bit_cnt <= target)
            cut_on = 1'b0;
      end else begin
         case (frame_st)
            dcctwg_pkg::ST_IDLE, dcctwg_pkg::ST_PRE: begin
               if (frame_st == dcctwg_pkg::ST_IDLE) begin
                  frame_st = dcctwg_pkg::ST_PRE;
                  if (cfg_shadow.railcom_enable && !next_svc) begin
                     cut_on       = 1'b1;
                     half_pending = 1'b1;
                  end
               end
               hp = half_pending ? dcctwg_pkg::HP_HALF : dcctwg_pkg::HP_ONE;
               if (bit_cnt <= 6'd1) begin
                  cut_on = 1'b0;
                  if (next_svc) begin
                     bit_cnt  = cfg_shadow.long_preamble_extra;
                     frame_st = dcctwg_pkg::ST_LONGPRE;
                  end else begin
                     bit_cnt  = 6'd0;
                     frame_st = dcctwg_pkg::ST_BSTART;
                  end
               end else
                  bit_cnt = bit_cnt - 6'd1;
            end
            dcctwg_pkg::ST_LONGPRE: begin
               hp = dcctwg_pkg::HP_ONE;
               if (bit_cnt <= 6'd1) begin
                  bit_cnt  = 6'd0;
                  frame_st = dcctwg_pkg::ST_BSTART;
               end else
                  bit_cnt = bit_cnt - 6'd1;
            end
            dcctwg_pkg::ST_BSTART: begin
               // First start bit: load the offered packet, or the idle packet if
               // no packet was offered.
               hp = dcctwg_pkg::HP_ZHIGH;
               if (buf_free) begin
                  for (i = 0; i < PKT_MAX; i++) send_buf[i] = 8'h00;
                  send_buf[0] = dcctwg_pkg::IDLE_BYTE0;
                  send_buf[1] = dcctwg_pkg::IDLE_BYTE1;
                  send_buf[2] = dcctwg_pkg::IDLE_BYTE2;
                  send_len    = 3'(dcctwg_pkg::IDLE_LEN);
                  idle_sub    = 1'b1;
               end else begin
                  for (i = 0; i < PKT_MAX; i++) send_buf[i] = next_buf[i];
                  send_len = next_len;
               end
               if (send_len == 3'd0) send_len = 3'd1;
               if (send_len > PKT_MAX) send_len = 3'(PKT_MAX);
               buf_free  = 1'b1;
               frame_st  = dcctwg_pkg::ST_BYTE;
               bit_cnt   = dcctwg_pkg::BITS_PER_BYTE;
               bytes_rem = send_len;
            end
            dcctwg_pkg::ST_NEXTBYTE: begin
               hp       = dcctwg_pkg::HP_ZHIGH;
               frame_st = dcctwg_pkg::ST_BYTE;
               bit_cnt  = dcctwg_pkg::BITS_PER_BYTE;
            end
            dcctwg_pkg::ST_BYTE: begin
               idx        = (bytes_rem <= send_len) ? send_len - bytes_rem : 3'd0;
               shift_full = bit_cnt - 6'd1;
               sh         = (bit_cnt >= 6'd1 && bit_cnt <= 6'd8) ? shift_full[2:0] : 3'd0;
               cur        = (idx < PKT_MAX) ? send_buf[idx] : 8'h00;
               hp         = cur[sh] ? dcctwg_pkg::HP_ONE : dcctwg_pkg::HP_ZHIGH;
               if (bit_cnt <= 6'd1) begin
                  bit_cnt = 6'd0;
                  if (bytes_rem <= 3'd1) begin
                     bytes_rem = 3'd0;
                     frame_st  = dcctwg_pkg::ST_END;
                  end else begin
                     bytes_rem = bytes_rem - 3'd1;
                     frame_st  = dcctwg_pkg::ST_NEXTBYTE;
                  end
               end else
                  bit_cnt = bit_cnt - 6'd1;
            end
            default: begin
               hp       = dcctwg_pkg::HP_ONE;
               frame_st = dcctwg_pkg::ST_IDLE;
               bit_cnt  = cfg_shadow.preamble_bits;
            end
         endcase
      end

      last_hp = hp;
      o = {hp, ra, rb, cfg_shadow.s88_enable & phase_level, cut_on, buf_free, idle_sub};
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Directed table helpers
   // ---------------------------------------------------------------------------
   function automatic void add_req(input dcctwg_pkg::item_kind_type kind,
                                   input logic power,
                                   input logic [47:0] bytes, input logic [2:0] len,
                                   input logic svc, input logic typed,
                                   input dcctwg_pkg::rsp_payload_type want);
      step_row_type row;
      row.kind    = ROW_REQ;
      row.req     = {kind, power, bytes, len, svc};
      row.csr_idx = 3'd0;
      row.csr_val = 6'd0;
      row.typed   = typed;
      row.want    = want;
      directed_steps.push_back(row);
   endfunction

   function automatic void add_csr(input logic [2:0] idx, input logic [5:0] val);
      step_row_type row;
      row         = '0;
      row.kind    = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      directed_steps.push_back(row);
   endfunction

   // Random request. Offers usually come when the next buffer is free. Sometimes
   // an offer overwrites a pending packet. In phase 2 no offer comes while the buffer is
   // free, so idle packets are substituted.
   function automatic dcctwg_pkg::req_payload_type make_random_request();
      dcctwg_pkg::req_payload_type r;
      int                          roll;
      roll   = $urandom_range(99);
      r.func = dcctwg_pkg::KIND_TICK;
      if ((buf_free && roll < offer_pct) || (!buf_free && roll < 2))
         r.func = dcctwg_pkg::KIND_OFFER;
      r.rail_power          = ($urandom_range(99) >= 10);
      r.packet_bytes[47:32] = 16'($urandom_range(16'hFFFF));
      r.packet_bytes[31:0]  = $urandom;
      roll = $urandom_range(99);
      if (roll < 5)
         r.packet_len = 3'd0;
      else if (roll < 10)
         r.packet_len = 3'd7;
      else
         r.packet_len = 3'($urandom_range(PKT_MAX, 1));
      r.packet_service = ($urandom_range(99) < 25);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Driving tasks. Each is called at a falling edge and returns at a falling edge.
   // ---------------------------------------------------------------------------
   task automatic send_request(input dcctwg_pkg::req_payload_type p, input logic typed,
                               input dcctwg_pkg::rsp_payload_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      pin_typed    = typed;
      pin_want     = want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_waveform_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [5:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [1:0] want,
                              input logic [1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Clock, watchdog, receiver stalls
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  CYCLE_LIMIT, expected_waveform_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // rsp_ready changes at the falling edge. stall_pct of 0 keeps it high.
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // ---------------------------------------------------------------------------
   // Monitor: all handshakes are sampled at the rising edge, before any
   // register in the block updates. A response is checked against the oldest
   // expectation. An accepted request adds its prediction. An accepted write
   // updates the shadow registers.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      dcctwg_pkg::rsp_payload_type want;
      dcctwg_pkg::rsp_payload_type predicted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_waveform_q.size() == 0) begin
               error_count++;
               $display("%0t: response with none expected, got %h", $time, rsp_payload);
            end else begin
               want = expected_waveform_q.pop_front();
               check_field("half_period", want.half_period, rsp_payload.half_period);
               check_field("rail_a", want.rail_a, rsp_payload.rail_a);
               check_field("rail_b", want.rail_b, rsp_payload.rail_b);
               check_field("aux_level", {1'b0, want.aux_level},
                           {1'b0, rsp_payload.aux_level});
               check_field("cutout_active", {1'b0, want.cutout_active},
                           {1'b0, rsp_payload.cutout_active});
               check_field("need_packet", {1'b0, want.need_packet},
                           {1'b0, rsp_payload.need_packet});
               check_field("idle_substituted", {1'b0, want.idle_substituted},
                           {1'b0, rsp_payload.idle_substituted});
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dcctwg_pkg::CSR_RAILCOM_ENABLE: cfg_shadow.railcom_enable = csr_wdata[0];
               dcctwg_pkg::CSR_S88_ENABLE:     cfg_shadow.s88_enable     = csr_wdata[0];
               dcctwg_pkg::CSR_PREAMBLE_BITS:  cfg_shadow.preamble_bits  = csr_wdata;
               dcctwg_pkg::CSR_CUTOUT_BITS:    cfg_shadow.cutout_bits    = csr_wdata;
               dcctwg_pkg::CSR_LONG_PRE_EXTRA: cfg_shadow.long_preamble_extra = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            // The predictor runs for typed rows too, so that its state stays current.
            predicted = predict_waveform(req_payload);
            expected_waveform_q.push_back(pin_typed ? pin_want : predicted);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      int                  phase_idx;
      int                  item_idx;
      int                  row_idx;
      dcctwg_pkg::cfg_type settings;
      step_row_type        row;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = dcctwg_pkg::CSR_RAILCOM_ENABLE;
      csr_wdata   = 6'd0;
      pin_typed   = 1'b0;
      pin_want    = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      offer_pct   = 15;
      reset_predictor();

      // Directed part. The registers hold their reset values except for the
      // two enables, so the preamble is 16 ones with a 4-bit cutout.
      add_csr(dcctwg_pkg::CSR_RAILCOM_ENABLE, 6'd1);
      add_csr(dcctwg_pkg::CSR_S88_ENABLE, 6'd1);
      // First high half: the preamble opens with the cutout and a half-length one
      add_req(dcctwg_pkg::KIND_TICK, 1'b1, '0, 3'd1, 1'b0, 1'b1,
              {dcctwg_pkg::HP_HALF, dcctwg_pkg::RAIL_HIGH, dcctwg_pkg::RAIL_HIGH, 4'b1110});
      // Second half-length one: the phase holds, only rail A is in cutout
      add_req(dcctwg_pkg::KIND_TICK, 1'b1, '1, 3'd7, 1'b1, 1'b1,
              {dcctwg_pkg::HP_HALF, dcctwg_pkg::RAIL_CUT, dcctwg_pkg::RAIL_HOLD, 4'b1110});
      // Power off: both rails hold
      add_req(dcctwg_pkg::KIND_TICK, 1'b0, '0, 3'd0, 1'b0, 1'b1,
              {dcctwg_pkg::HP_ONE, dcctwg_pkg::RAIL_HOLD, dcctwg_pkg::RAIL_HOLD, 4'b0110});
      add_req(dcctwg_pkg::KIND_TICK, 1'b1, '0, 3'd1, 1'b0, 1'b1,
              {dcctwg_pkg::HP_ONE, dcctwg_pkg::RAIL_CUT, dcctwg_pkg::RAIL_CUT, 4'b1110});
      // Offers: length 0 is taken as 1, length 7 as 6. Later offers overwrite earlier ones.
      add_req(dcctwg_pkg::KIND_OFFER, 1'b0, 48'hFFFF_FFFF_FFFF, 3'd0, 1'b0, 1'b1,
              {dcctwg_pkg::HP_ONE, dcctwg_pkg::RAIL_HOLD, dcctwg_pkg::RAIL_HOLD, 4'b1100});
      add_req(dcctwg_pkg::KIND_OFFER, 1'b1, 48'h0000_0000_0000, 3'd7, 1'b1, 1'b1,
              {dcctwg_pkg::HP_ONE, dcctwg_pkg::RAIL_HOLD, dcctwg_pkg::RAIL_HOLD, 4'b1100});
      add_req(dcctwg_pkg::KIND_OFFER, 1'b1, 48'hAAAA_AAAA_AAAA, 3'd6, 1'b0, 1'b1,
              {dcctwg_pkg::HP_ONE, dcctwg_pkg::RAIL_HOLD, dcctwg_pkg::RAIL_HOLD, 4'b1100});
      // Longest preamble and a cutout end near the current count
      add_csr(dcctwg_pkg::CSR_PREAMBLE_BITS, 6'd63);
      add_csr(dcctwg_pkg::CSR_CUTOUT_BITS, 6'd50);
      add_csr(dcctwg_pkg::CSR_LONG_PRE_EXTRA, 6'd1);
      for (row_idx = 0; row_idx < 6; row_idx++)
         add_req(dcctwg_pkg::KIND_TICK, row_idx != 2, 48'h5555_5555_5555, 3'd2, 1'b0,
                 1'b0, '0);
      add_req(dcctwg_pkg::KIND_OFFER, 1'b1, 48'h5555_5555_5555, 3'd3, 1'b1, 1'b0, '0);
      add_req(dcctwg_pkg::KIND_OFFER, 1'b0, 48'h0123_4567_89AB, 3'd2, 1'b0, 1'b0, '0);
      for (row_idx = 0; row_idx < 6; row_idx++)
         add_req(dcctwg_pkg::KIND_TICK, row_idx[0], 48'hFEDC_BA98_7654, 3'd4, 1'b1,
                 1'b0, '0);
      add_req(dcctwg_pkg::KIND_OFFER, 1'b1, 48'h8000_0000_0001, 3'd5, 1'b1, 1'b0, '0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[row_idx]) begin
         row = directed_steps[row_idx];
         if (row.kind == ROW_CSR) begin
            drain_results();
            write_csr(row.csr_idx, row.csr_val);
         end else
            send_request(row.req, row.typed, row.want);
      end

      // Random phases. Each phase starts after every response of the previous
      // phase has arrived, so register writes only happen while the block is idle.
      for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
         drain_results();
         // railcom, s88, preamble, cutout, long preamble extra
         case (phase_idx)
            0: settings = {1'b1, 1'b1, 6'd1, 6'd0, 6'd1};
            1: settings = {1'b1, 1'b0, 6'd63, 6'd62, 6'd63};
            2: settings = {1'b0, 1'b1, 6'd4, 6'd2, 6'd3};
            3: settings = {1'b1, 1'b1, 6'd3, 6'd62, 6'd2}; // cutout covers the whole preamble
            5: settings = {1'b1, 1'b1, dcctwg_pkg::PREAMBLE_RESET, dcctwg_pkg::CUTOUT_RESET,
                           dcctwg_pkg::LONG_PRE_RESET};
            default: begin
               settings.railcom_enable      = 1'($urandom_range(1));
               settings.s88_enable          = 1'($urandom_range(1));
               settings.preamble_bits       = 6'($urandom_range(10, 1));
               settings.cutout_bits         = 6'($urandom_range(10, 0));
               settings.long_preamble_extra = 6'($urandom_range(6, 1));
            end
         endcase
         write_csr(dcctwg_pkg::CSR_RAILCOM_ENABLE, {5'd0, settings.railcom_enable});
         write_csr(dcctwg_pkg::CSR_S88_ENABLE, {5'd0, settings.s88_enable});
         write_csr(dcctwg_pkg::CSR_PREAMBLE_BITS, settings.preamble_bits);
         write_csr(dcctwg_pkg::CSR_CUTOUT_BITS, settings.cutout_bits);
         write_csr(dcctwg_pkg::CSR_LONG_PRE_EXTRA, settings.long_preamble_extra);

         // Idle modes rotate: none, sender idle, receiver stalls, both
         case (phase_idx % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 23; stall_pct = 23; end
         endcase
         // Phase 2 offers no packet while the next buffer is free, so frames carry the idle packet once none is pending
         offer_pct = (phase_idx == 2) ? 0 : (phase_idx >= 6) ? $urandom_range(25) : 15;

         for (item_idx = 0; item_idx < PHASE_ITEMS; item_idx++)
            send_request(make_random_request(), 1'b0, '0);
      end

      drain_results();
      // Keep waiting to catch any extra response
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: files.f
src/dcctwg_pkg.sv
src/dcctwg_front.sv
src/dcctwg_back.sv
src/dcc_track_waveform_generator_top.sv
dv/testbench.sv
